// ===== hdl/mfcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mfcp_pkg;

  localparam int unsigned POS_W           = 11;
  localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
  localparam int unsigned MAX_FRAME_BYTES = 1024;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_SHORT   = 2'd2
  } status_e;

  typedef struct packed {
    logic       has_pay;
    logic [7:0] pay;
    logic       has_sum;
    logic [7:0] hdr;
    logic [7:0] len;
    status_e    status;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/mfcp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfcp_front
  import mfcp_pkg::*;
#(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       end_of_frame_i,
  output cmd_t            cmd_o,
  output logic            cmd_push_o
);

  localparam logic [POS_W-1:0] MaxPos = POS_W'(MaxFrameBytes);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       held_q, held_d;
  logic             held_vld_q, held_vld_d;
  logic [7:0]       hdr_q, hdr_d;
  logic [7:0]       len_q, len_d;
  logic [POS_W:0]   total;
  logic [POS_W:0]   need;
  logic [POS_W:0]   pay_end;

  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    hdr_d      = hdr_q;
    len_d      = len_q;
    cmd_o      = '0;
    cmd_push_o = 1'b0;
    total      = {1'b0, pos_q} + (POS_W+1)'(1);
    need       = (POS_W+1)'(4) + {{(POS_W-7){1'b0}}, len_q};
    pay_end    = (POS_W+1)'(3) + {{(POS_W-7){1'b0}}, len_q};
    if (accept_i) begin
      cmd_o.has_pay = held_vld_q;
      cmd_o.pay     = held_q;
      held_vld_d    = 1'b0;
      held_d        = '0;
      if (end_of_frame_i) begin
        cmd_o.has_sum = 1'b1;
        cmd_o.hdr     = hdr_q;
        cmd_o.len     = len_q;
        if (total < need) begin
          cmd_o.status = ST_SHORT;
        end else if (pos_q >= MaxPos || rx_byte_i != sum_q) begin
          cmd_o.status = ST_BAD_SUM;
        end else begin
          cmd_o.status = ST_GOOD;
        end
        pos_d = '0;
        sum_d = '0;
        hdr_d = '0;
        len_d = '0;
      end else begin
        if (pos_q == POS_W'(0)) begin
          hdr_d = rx_byte_i;
        end
        if (pos_q == POS_W'(2)) begin
          len_d = rx_byte_i;
        end
        if (pos_q >= POS_W'(3) && {1'b0, pos_q} < pay_end) begin
          held_d     = rx_byte_i;
          held_vld_d = 1'b1;
        end
        sum_d = sum_q + rx_byte_i;
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + POS_W'(1);
        end
      end
      cmd_push_o = cmd_o.has_pay | cmd_o.has_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sum_q      <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      hdr_q      <= '0;
      len_q      <= '0;
    end else begin
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      hdr_q      <= hdr_d;
      len_q      <= len_d;
    end
  end

  held_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_vld_q |-> pos_q >= POS_W'(4))
    else $error("payload byte held before header complete");

  frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_frame_i) |=> (pos_q == '0 && sum_q == '0 && !held_vld_q))
    else $error("frame state not cleared after check byte");

endmodule

`default_nettype wire

// ===== hdl/mfcp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfcp_queue
  import mfcp_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("word pushed into full queue");

endmodule

`default_nettype wire

// ===== hdl/mfcp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfcp_back
  import mfcp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cmd_t      cmd_i,
  input  wire logic cmd_empty_i,
  output logic      cmd_pop_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output logic       result_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [2:0] frame_type_o,
  output logic       more_fragment_o,
  output logic       more_sessions_o,
  output logic [2:0] node_address_o,
  output logic [7:0] payload_length_o,
  output logic [1:0] frame_status_o,
  output logic       frame_done_o
);

  cmd_t cur_q;
  logic cur_vld_q, cur_vld_d;
  logic pay_done_q, pay_done_d;
  logic show_sum;
  logic taken;
  logic finish;

  assign show_sum  = !cur_q.has_pay || pay_done_q;
  assign empty_o   = !cur_vld_q;
  assign taken     = pop_i && cur_vld_q;
  assign finish    = taken && (show_sum || !cur_q.has_sum);
  assign cmd_pop_o = !cmd_empty_i && (!cur_vld_q || finish);

  always_comb begin
    cur_vld_d  = cur_vld_q;
    pay_done_d = pay_done_q;
    if (taken && !show_sum) begin
      pay_done_d = 1'b1;
    end
    if (finish) begin
      cur_vld_d = 1'b0;
    end
    if (cmd_pop_o) begin
      cur_vld_d  = 1'b1;
      pay_done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q  <= 1'b0;
      pay_done_q <= 1'b0;
    end else begin
      cur_vld_q  <= cur_vld_d;
      pay_done_q <= pay_done_d;
    end
  end

  always_comb begin
    result_kind_o    = show_sum ? KIND_SUMMARY : KIND_PAYLOAD;
    payload_byte_o   = show_sum ? 8'd0 : cur_q.pay;
    frame_type_o     = show_sum ? cur_q.hdr[7:5] : 3'd0;
    more_fragment_o  = show_sum ? cur_q.hdr[4] : 1'b0;
    more_sessions_o  = show_sum ? cur_q.hdr[3] : 1'b0;
    node_address_o   = show_sum ? cur_q.hdr[2:0] : 3'd0;
    payload_length_o = show_sum ? cur_q.len : 8'd0;
    frame_status_o   = show_sum ? cur_q.status : ST_GOOD;
    frame_done_o     = show_sum;
  end

  summary_follows_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (taken && !show_sum && cur_q.has_sum) |=> (cur_vld_q && show_sum))
    else $error("summary lost after payload word");

  word_has_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q |-> (cur_q.has_pay || cur_q.has_sum))
    else $error("empty command word loaded");

endmodule

`default_nettype wire

// ===== hdl/mac_frame_checksum_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake        | words
// input    | push / full      | rx_byte_i, end_of_frame_i
// result   | empty / pop      | result_kind_o ... frame_done_o
//
// One input byte is taken per cycle while full is low. A summary word is registered
// in the command queue and then in the output stage before it is on the result ports;
// a payload byte waits for the next accepted byte of its frame, then takes that path.
// The check byte of a frame may yield two words (last payload byte, then summary);
// the output stage hands out one word per cycle while pop is high.
// A command queue of Depth entries parts the parser from the output stage, so
// input stalls only when that queue fills.
// Reset clears the frame state, the queue and the output stage at once.

module mac_frame_checksum_parser
  import mfcp_pkg::*;
#(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES,
  parameter int unsigned Depth         = QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       end_of_frame_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            result_kind_o,
  output logic [7:0]      payload_byte_o,
  output logic [2:0]      frame_type_o,
  output logic            more_fragment_o,
  output logic            more_sessions_o,
  output logic [2:0]      node_address_o,
  output logic [7:0]      payload_length_o,
  output logic [1:0]      frame_status_o,
  output logic            frame_done_o
);

  cmd_t front_cmd;
  logic front_push;
  cmd_t queue_cmd;
  logic queue_empty;
  logic queue_pop;
  logic accept;

  assign accept = push && !full;

  mfcp_front #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .end_of_frame_i(end_of_frame_i),
    .cmd_o         (front_cmd),
    .cmd_push_o    (front_push)
  );

  mfcp_queue #(
    .Depth(Depth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .data_i (front_cmd),
    .full_o (full),
    .pop_i  (queue_pop),
    .data_o (queue_cmd),
    .empty_o(queue_empty)
  );

  mfcp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (queue_cmd),
    .cmd_empty_i     (queue_empty),
    .cmd_pop_o       (queue_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .result_kind_o   (result_kind_o),
    .payload_byte_o  (payload_byte_o),
    .frame_type_o    (frame_type_o),
    .more_fragment_o (more_fragment_o),
    .more_sessions_o (more_sessions_o),
    .node_address_o  (node_address_o),
    .payload_length_o(payload_length_o),
    .frame_status_o  (frame_status_o),
    .frame_done_o    (frame_done_o)
  );

endmodule

`default_nettype wire
